FILE: sv/solcd_pkg.sv
// Shared constants and types for the serial output latch command decoder.
// No dependencies; compile first.
package solcd_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ID_W    = 5;
  localparam int unsigned IMAGE_W = 64;
  localparam int unsigned POS_W   = 3;

  // Frame positions
  localparam logic [POS_W-1:0] POS_START = 3'd0;
  localparam logic [POS_W-1:0] POS_REG   = 3'd1;
  localparam logic [POS_W-1:0] POS_VALUE = 3'd2;
  localparam logic [POS_W-1:0] POS_IDLE  = 3'd4;

  // Addressing
  localparam logic [ID_W-1:0] ADDR_BROADCAST = 5'd0;
  localparam logic [ID_W-1:0] DEVICE_ID_MAX  = 5'd30;

  // Register numbers
  localparam logic [BYTE_W-1:0] REG_RESET     = 8'd128;
  localparam logic [BYTE_W-1:0] REG_CHANGE_ID = 8'd129;
  localparam logic [BYTE_W-1:0] REG_BIT_LO_A  = 8'd88;
  localparam logic [BYTE_W-1:0] REG_BIT_HI_A  = 8'd119;
  localparam logic [BYTE_W-1:0] REG_BIT_LO_B  = 8'd200;
  localparam logic [BYTE_W-1:0] REG_BIT_HI_B  = 8'd231;
  localparam logic [BYTE_W-1:0] REG_BYTE_LO_A = 8'd120;
  localparam logic [BYTE_W-1:0] REG_BYTE_HI_A = 8'd123;
  localparam logic [BYTE_W-1:0] REG_BYTE_LO_B = 8'd232;
  localparam logic [BYTE_W-1:0] REG_BYTE_HI_B = 8'd235;

  // Address-change sequence
  localparam logic [BYTE_W-1:0] ID_SEQ_ABORT    = 8'd5;
  localparam logic [BYTE_W-1:0] ID_SEQ_DONE_MIN = 8'd2;

  // Latch image: eight bytes, byte k at bits 8k+7..8k
  typedef logic [7:0][BYTE_W-1:0] latch_t;

endpackage

FILE: sv/solcd_in_if.sv
// Input channel of the command decoder: one received byte per transaction.
// Depends on solcd_pkg.
interface solcd_in_if;
  logic                           valid;
  logic                           ready;
  logic [solcd_pkg::BYTE_W-1:0]   rx_byte;
  logic                           line_error;
  logic                           setup_jumper;

  modport source (output valid, output rx_byte, output line_error, output setup_jumper,
                  input ready);
  modport sink   (input valid, input rx_byte, input line_error, input setup_jumper,
                  output ready);
endinterface

FILE: sv/solcd_out_if.sv
// Result channel of the command decoder: latch image and flags per transaction.
// Depends on solcd_pkg.
interface solcd_out_if;
  logic                            valid;
  logic                            ready;
  logic [solcd_pkg::IMAGE_W-1:0]   output_image;
  logic                            reset_request;
  logic                            store_id;
  logic [solcd_pkg::ID_W-1:0]      new_id;
  logic                            jumper_missing;

  modport source (output valid, output output_image, output reset_request, output store_id,
                  output new_id, output jumper_missing, input ready);
  modport sink   (input valid, input output_image, input reset_request, input store_id,
                  input new_id, input jumper_missing, output ready);
endinterface

FILE: sv/serial_output_latch_command_decoder_top.sv
// Serial output latch command decoder, top level.
// Depends on solcd_pkg, solcd_in_if and solcd_out_if.

// Each received byte passes through an input register, is decoded by one level of
// compare and select logic against the frame state and the 64-bit latch image, and
// lands in a result register together with the updated image and the flags. One byte
// is taken every cycle unless both registers are full and the sink stalls, and each
// byte gives exactly one result; input and result registers each hold a transaction,
// so the input stays open while a result waits for the sink until the input register
// is full too. Bytes flagged with a line error change nothing and give a result with
// all flags low. The user must write device_id through cfg_we / cfg_wdata while no
// transaction is in flight (not enforced); values above 30 are clamped to 30.
module serial_output_latch_command_decoder_top (
  input  logic                         clk,
  input  logic                         rst_n,
  solcd_in_if.sink                     in_ch,
  solcd_out_if.source                  out_ch,
  input  logic                         cfg_we,
  input  logic [solcd_pkg::ID_W-1:0]   cfg_wdata
);

  // Configuration
  logic [solcd_pkg::ID_W-1:0] device_id_r;

  // Input stage
  logic                           s1_valid_r;
  logic [solcd_pkg::BYTE_W-1:0]   s1_byte_r;
  logic                           s1_err_r;
  logic                           s1_jumper_r;

  // Decoder state
  solcd_pkg::latch_t              latch_r, latch_nxt;
  logic [solcd_pkg::POS_W-1:0]    fpos_r, fpos_nxt;
  logic [solcd_pkg::BYTE_W-1:0]   regnum_r, regnum_nxt;
  logic [solcd_pkg::BYTE_W-1:0]   value_r, value_nxt;
  logic [solcd_pkg::BYTE_W-1:0]   idseq_r, idseq_nxt;
  logic [solcd_pkg::ID_W-1:0]     pend_id_r, pend_id_nxt;

  // Result stage
  logic                           out_valid_r;
  logic [solcd_pkg::IMAGE_W-1:0]  out_image_r;
  logic                           out_rst_r, out_rst_nxt;
  logic                           out_store_r, out_store_nxt;
  logic [solcd_pkg::ID_W-1:0]     out_id_r, out_id_nxt;
  logic                           out_nojmp_r, out_nojmp_nxt;

  // Handshake
  logic out_adv;
  logic s1_fire;
  logic in_fire;

  assign out_adv     = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_adv;
  assign in_ch.ready = !s1_valid_r || out_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Load device_id, clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r <= '0;
    end else if (cfg_we) begin
      device_id_r <= (cfg_wdata > solcd_pkg::DEVICE_ID_MAX) ? solcd_pkg::DEVICE_ID_MAX
                                                             : cfg_wdata;
    end
  end

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r   <= in_ch.rx_byte;
      s1_err_r    <= in_ch.line_error;
      s1_jumper_r <= in_ch.setup_jumper;
    end
  end

  // Decode one byte against the frame state
  always_comb begin
    logic [solcd_pkg::POS_W-1:0]  pos;
    logic [solcd_pkg::POS_W-1:0]  fpos_tmp;
    logic                         advance;
    logic [solcd_pkg::ID_W-1:0]   addr;
    logic [solcd_pkg::BYTE_W-1:0] rnum;
    logic [solcd_pkg::BYTE_W-1:0] ofs;
    logic [solcd_pkg::BYTE_W-1:0] vnew;
    logic [solcd_pkg::BYTE_W-1:0] seq_inc;
    logic [2:0]                   fld;
    logic [solcd_pkg::ID_W-1:0]   adr;

    latch_nxt     = latch_r;
    fpos_nxt      = fpos_r;
    regnum_nxt    = regnum_r;
    value_nxt     = value_r;
    idseq_nxt     = idseq_r;
    pend_id_nxt   = pend_id_r;
    out_rst_nxt   = 1'b0;
    out_store_nxt = 1'b0;
    out_id_nxt    = '0;
    out_nojmp_nxt = 1'b0;

    pos      = s1_byte_r[7] ? solcd_pkg::POS_START : fpos_r;
    fpos_tmp = pos;
    advance  = 1'b1;
    addr     = s1_byte_r[6:2];
    rnum     = regnum_r | s1_byte_r;
    ofs      = '0;
    vnew     = value_r | {s1_byte_r[6:0], 1'b0};
    seq_inc  = idseq_r + 8'd1;
    fld      = vnew[7:5];
    adr      = vnew[4:0];

    if (!s1_err_r) begin
      case (pos)
        solcd_pkg::POS_START: begin
          if (addr != device_id_r && addr != solcd_pkg::ADDR_BROADCAST) begin
            // Foreign frame: drop until the next start byte
            fpos_tmp = solcd_pkg::POS_IDLE;
            advance  = 1'b0;
          end else begin
            regnum_nxt = {s1_byte_r[1], 7'b0};
            value_nxt  = {7'b0, s1_byte_r[0]};
          end
        end
        solcd_pkg::POS_REG: begin
          regnum_nxt = rnum;
          if (rnum == solcd_pkg::REG_RESET) begin
            out_rst_nxt = 1'b1;
            fpos_tmp    = solcd_pkg::POS_IDLE;
          end else if (rnum inside {[solcd_pkg::REG_BIT_LO_A:solcd_pkg::REG_BIT_HI_A]}) begin
            ofs = rnum - solcd_pkg::REG_BIT_LO_A;
            latch_nxt[{1'b0, ofs[4:3]}][ofs[2:0]] = (value_r != '0);
            fpos_tmp = solcd_pkg::POS_IDLE;
          end else if (rnum inside {[solcd_pkg::REG_BIT_LO_B:solcd_pkg::REG_BIT_HI_B]}) begin
            ofs = rnum - solcd_pkg::REG_BIT_LO_B;
            latch_nxt[{1'b1, ofs[4:3]}][ofs[2:0]] = (value_r != '0);
            fpos_tmp = solcd_pkg::POS_IDLE;
          end
        end
        solcd_pkg::POS_VALUE: begin
          value_nxt = vnew;
          if (regnum_r == solcd_pkg::REG_CHANGE_ID) begin
            if (!s1_jumper_r) begin
              out_nojmp_nxt = 1'b1;
            end else if (fld == 3'd0) begin
              // Open the sequence with the proposed address
              idseq_nxt   = '0;
              pend_id_nxt = adr;
            end else if (seq_inc != {5'b0, fld} || pend_id_r != adr) begin
              idseq_nxt = solcd_pkg::ID_SEQ_ABORT;
            end else begin
              idseq_nxt = seq_inc;
              if (seq_inc >= solcd_pkg::ID_SEQ_DONE_MIN) begin
                out_store_nxt = 1'b1;
                out_id_nxt    = pend_id_r;
                out_rst_nxt   = 1'b1;
                fpos_tmp      = solcd_pkg::POS_IDLE;
              end
            end
          end else if (regnum_r inside
                       {[solcd_pkg::REG_BYTE_LO_A:solcd_pkg::REG_BYTE_HI_A]}) begin
            ofs = regnum_r - solcd_pkg::REG_BYTE_LO_A;
            latch_nxt[{1'b0, ofs[1:0]}] = vnew;
            fpos_tmp = solcd_pkg::POS_IDLE;
          end else if (regnum_r inside
                       {[solcd_pkg::REG_BYTE_LO_B:solcd_pkg::REG_BYTE_HI_B]}) begin
            ofs = regnum_r - solcd_pkg::REG_BYTE_LO_B;
            latch_nxt[{1'b1, ofs[1:0]}] = vnew;
            fpos_tmp = solcd_pkg::POS_IDLE;
          end
        end
        default: begin
          // Byte outside any frame
          fpos_tmp = solcd_pkg::POS_IDLE;
        end
      endcase
      fpos_nxt = advance ? fpos_tmp + 3'd1 : fpos_tmp;
    end
  end

  // Update decoder state on each decoded transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r   <= '0;
      fpos_r    <= solcd_pkg::POS_IDLE;
      regnum_r  <= '0;
      value_r   <= '0;
      idseq_r   <= '0;
      pend_id_r <= '0;
    end else if (s1_fire) begin
      latch_r   <= latch_nxt;
      fpos_r    <= fpos_nxt;
      regnum_r  <= regnum_nxt;
      value_r   <= value_nxt;
      idseq_r   <= idseq_nxt;
      pend_id_r <= pend_id_nxt;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_image_r <= latch_nxt;
      out_rst_r   <= out_rst_nxt;
      out_store_r <= out_store_nxt;
      out_id_r    <= out_id_nxt;
      out_nojmp_r <= out_nojmp_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.output_image   = out_image_r;
  assign out_ch.reset_request  = out_rst_r;
  assign out_ch.store_id       = out_store_r;
  assign out_ch.new_id         = out_id_r;
  assign out_ch.jumper_missing = out_nojmp_r;

  // A byte with a line error leaves the image and frame position alone
  a_err_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_err_r) |=> ($stable(latch_r) && $stable(fpos_r)))
    else $error("line error byte changed decoder state");

  // After any decoded byte the frame never sits at the start position
  a_pos_never_start: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> (fpos_r != solcd_pkg::POS_START))
    else $error("frame position left at start after a byte");

  // A stored address always comes with a reset request and never with a refusal
  a_store_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_store_r) |-> (out_rst_r && !out_nojmp_r))
    else $error("store_id without reset_request or with jumper_missing");

  // Both stages full and sink stalled: input must be closed
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input open while both stages are full");

endmodule
